FILE: sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SWS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sws assertion failed");

// next-cycle implication
`define SWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sws assertion failed");

`endif

FILE: sv/sws_pkg.sv
package sws_pkg;

    localparam int X_W     = 24;
    localparam int T_W     = 20;
    localparam int THR_W   = 21;
    localparam int SLOPE_W = 48;
    localparam int FRAC_W  = 16;

    localparam int SX_W    = 30;
    localparam int ST_W    = 26;
    localparam int STT_W   = 46;
    localparam int SXT_W   = 50;

    localparam int MA_W    = 31;
    localparam int MB_W    = 27;
    localparam int PROD_W  = MA_W + MB_W;
    localparam int DEN_W   = 54;
    localparam int NUM_W   = 58;
    localparam int MAG_W   = 57;

    localparam int DVD_W   = MAG_W + FRAC_W;
    localparam int DIVD_W  = DEN_W - 1;
    localparam int REM_W   = DIVD_W + 1;
    localparam int Q_W     = SLOPE_W + 1;
    localparam int CNT_W   = $clog2(DVD_W);

    localparam logic [Q_W-1:0] Q_CAP   = {1'b1, {SLOPE_W{1'b0}}};
    localparam logic [Q_W-1:0] POS_MAX = {2'b00, {(SLOPE_W-1){1'b1}}};
    localparam logic [Q_W-1:0] NEG_MAX = {2'b01, {(SLOPE_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_MXT,
        S_MOXT,
        S_MTT,
        S_MOTT,
        S_MSQ,
        S_MSXT,
        S_NUM,
        S_CHECK,
        S_DSTART,
        S_DWAIT,
        S_DONE
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_MXT,
        OP_MOXT,
        OP_MTT,
        OP_MOTT,
        OP_MSQ,
        OP_MSXT,
        OP_NUM,
        OP_CHECK
    } t_op;

    typedef struct packed {
        t_op  op;
        logic div_start;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic degen;
        logic div_busy;
    } t_dstat;

endpackage

FILE: sv/sws_ctrl.sv
`include "assert_macros.svh"

module sws_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    input  logic           i_out_free,
    input  sws_pkg::t_dstat i_stat,
    output logic           o_s_ready,
    output sws_pkg::t_cmd  o_cmd
);

    sws_pkg::t_state r_state;
    sws_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sws_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sws_pkg::S_IDLE: begin
                if (i_s_valid) begin
                    n_state = sws_pkg::S_MXT;
                end
            end
            sws_pkg::S_MXT:    n_state = sws_pkg::S_MOXT;
            sws_pkg::S_MOXT:   n_state = sws_pkg::S_MTT;
            sws_pkg::S_MTT:    n_state = sws_pkg::S_MOTT;
            sws_pkg::S_MOTT:   n_state = sws_pkg::S_MSQ;
            sws_pkg::S_MSQ:    n_state = sws_pkg::S_MSXT;
            sws_pkg::S_MSXT:   n_state = sws_pkg::S_NUM;
            sws_pkg::S_NUM:    n_state = sws_pkg::S_CHECK;
            sws_pkg::S_CHECK: begin
                n_state = i_stat.degen ? sws_pkg::S_DONE : sws_pkg::S_DSTART;
            end
            sws_pkg::S_DSTART: n_state = sws_pkg::S_DWAIT;
            sws_pkg::S_DWAIT: begin
                if (!i_stat.div_busy) begin
                    n_state = sws_pkg::S_DONE;
                end
            end
            sws_pkg::S_DONE: begin
                if (i_out_free) begin
                    n_state = sws_pkg::S_IDLE;
                end
            end
            default: n_state = sws_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_s_ready       = 1'b0;
        o_cmd.op        = sws_pkg::OP_NONE;
        o_cmd.div_start = 1'b0;
        o_cmd.load_out  = 1'b0;
        case (r_state)
            sws_pkg::S_IDLE: begin
                o_s_ready = i_rst_n;
                if (i_s_valid && i_rst_n) begin
                    o_cmd.op = sws_pkg::OP_ACCEPT;
                end
            end
            sws_pkg::S_MXT:    o_cmd.op = sws_pkg::OP_MXT;
            sws_pkg::S_MOXT:   o_cmd.op = sws_pkg::OP_MOXT;
            sws_pkg::S_MTT:    o_cmd.op = sws_pkg::OP_MTT;
            sws_pkg::S_MOTT:   o_cmd.op = sws_pkg::OP_MOTT;
            sws_pkg::S_MSQ:    o_cmd.op = sws_pkg::OP_MSQ;
            sws_pkg::S_MSXT:   o_cmd.op = sws_pkg::OP_MSXT;
            sws_pkg::S_NUM:    o_cmd.op = sws_pkg::OP_NUM;
            sws_pkg::S_CHECK:  o_cmd.op = sws_pkg::OP_CHECK;
            sws_pkg::S_DSTART: o_cmd.div_start = 1'b1;
            sws_pkg::S_DONE:   o_cmd.load_out = i_out_free;
            default: begin
            end
        endcase
    end

    `SWS_ASSERT_NXT(a_accept_seq, i_clk, i_rst_n, o_cmd.op == sws_pkg::OP_ACCEPT, r_state == sws_pkg::S_MXT)
    `SWS_ASSERT_NXT(a_start_wait, i_clk, i_rst_n, o_cmd.div_start, i_stat.div_busy)

endmodule

FILE: sv/sws_div.sv
`include "assert_macros.svh"

module sws_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [sws_pkg::MAG_W-1:0]    i_mag,
    input  logic [sws_pkg::DIVD_W-1:0]   i_den,
    output logic                         o_busy,
    output logic [sws_pkg::Q_W-1:0]      o_q
);

    logic                         r_busy;
    logic [sws_pkg::CNT_W-1:0]    r_cnt;
    logic [sws_pkg::DVD_W-1:0]    r_dvd;
    logic [sws_pkg::REM_W-1:0]    r_rem;
    logic [sws_pkg::Q_W-1:0]      r_q;

    logic [sws_pkg::REM_W-1:0]    rem_sh;
    logic                         ge;
    logic [sws_pkg::REM_W-1:0]    n_rem;
    logic [sws_pkg::Q_W-1:0]      q_sh;
    logic [sws_pkg::Q_W-1:0]      n_q;

    // one restoring step per cycle, quotient sticks at the cap
    always_comb begin
        rem_sh = {r_rem[sws_pkg::REM_W-2:0], r_dvd[sws_pkg::DVD_W-1]};
        ge     = rem_sh >= {1'b0, i_den};
        n_rem  = ge ? rem_sh - {1'b0, i_den} : rem_sh;
        q_sh   = {r_q[sws_pkg::Q_W-2:0], ge};
        if (r_q >= sws_pkg::Q_CAP) begin
            n_q = sws_pkg::Q_CAP;
        end else if (q_sh > sws_pkg::Q_CAP) begin
            n_q = sws_pkg::Q_CAP;
        end else begin
            n_q = q_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= sws_pkg::CNT_W'(sws_pkg::DVD_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= {i_mag, {sws_pkg::FRAC_W{1'b0}}};
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[sws_pkg::DVD_W-2:0], 1'b0};
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

    `SWS_ASSERT_NXT(a_div_last, i_clk, i_rst_n, r_busy && r_cnt == '0 && !i_start, !r_busy)
    `SWS_ASSERT_NOW(a_q_capped, i_clk, i_rst_n, r_busy, r_q <= sws_pkg::Q_CAP)

endmodule

FILE: sv/sws_dpath.sv
`include "assert_macros.svh"

module sws_dpath #(
    parameter int WINDOW = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sws_pkg::t_cmd                 i_cmd,
    input  logic signed [sws_pkg::X_W-1:0] i_x,
    input  logic [sws_pkg::T_W-1:0]       i_t,
    input  logic [sws_pkg::THR_W-1:0]     i_min_den,
    output sws_pkg::t_dstat               o_stat,
    output logic [sws_pkg::SLOPE_W-1:0]   o_slope,
    output logic                          o_degen
);

    localparam int IDX_W = $clog2(WINDOW);

    logic signed [sws_pkg::X_W-1:0]    r_vring [WINDOW];
    logic [sws_pkg::T_W-1:0]           r_tring [WINDOW];
    logic [WINDOW-1:0]                 r_vld;
    logic [IDX_W-1:0]                  r_idx;

    logic signed [sws_pkg::X_W-1:0]    r_x;
    logic [sws_pkg::T_W-1:0]           r_t;
    logic signed [sws_pkg::X_W-1:0]    r_ox;
    logic [sws_pkg::T_W-1:0]           r_ot;

    logic signed [sws_pkg::SX_W-1:0]   r_sx;
    logic [sws_pkg::ST_W-1:0]          r_st;
    logic [sws_pkg::STT_W-1:0]         r_stt;
    logic signed [sws_pkg::SXT_W-1:0]  r_sxt;

    logic signed [sws_pkg::PROD_W-1:0] r_prod;
    logic signed [sws_pkg::DEN_W-1:0]  r_den;
    logic signed [sws_pkg::NUM_W-1:0]  r_num;
    logic [sws_pkg::MAG_W-1:0]         r_mag;
    logic                              r_neg;

    logic signed [sws_pkg::MA_W-1:0]   ma;
    logic signed [sws_pkg::MB_W-1:0]   mb;
    logic [sws_pkg::THR_W-1:0]         thr;
    logic                              degen;
    logic                              div_busy;
    logic [sws_pkg::Q_W-1:0]           q;
    logic [sws_pkg::Q_W-1:0]           q_sat;

    // sample ring, old entry read before overwrite
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == sws_pkg::OP_ACCEPT) begin
            r_ox           <= r_vld[r_idx] ? r_vring[r_idx] : '0;
            r_ot           <= r_vld[r_idx] ? r_tring[r_idx] : '0;
            r_vring[r_idx] <= i_x;
            r_tring[r_idx] <= i_t;
            r_x            <= i_x;
            r_t            <= i_t;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_idx <= '0;
        end else if (i_cmd.op == sws_pkg::OP_ACCEPT) begin
            r_vld[r_idx] <= 1'b1;
            r_idx        <= (r_idx == IDX_W'(WINDOW - 1)) ? '0 : r_idx + 1'b1;
        end
    end

    // shared multiplier operand select
    always_comb begin
        ma = '0;
        mb = '0;
        case (i_cmd.op)
            sws_pkg::OP_MXT: begin
                ma = sws_pkg::MA_W'(r_x);
                mb = sws_pkg::MB_W'(r_t);
            end
            sws_pkg::OP_MOXT: begin
                ma = sws_pkg::MA_W'(r_ox);
                mb = sws_pkg::MB_W'(r_ot);
            end
            sws_pkg::OP_MTT: begin
                ma = sws_pkg::MA_W'(r_t);
                mb = sws_pkg::MB_W'(r_t);
            end
            sws_pkg::OP_MOTT: begin
                ma = sws_pkg::MA_W'(r_ot);
                mb = sws_pkg::MB_W'(r_ot);
            end
            sws_pkg::OP_MSQ: begin
                ma = sws_pkg::MA_W'(r_st);
                mb = sws_pkg::MB_W'(r_st);
            end
            sws_pkg::OP_MSXT: begin
                ma = sws_pkg::MA_W'(r_sx);
                mb = sws_pkg::MB_W'(r_st);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= sws_pkg::PROD_W'(ma) * sws_pkg::PROD_W'(mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sx  <= '0;
            r_st  <= '0;
            r_stt <= '0;
            r_sxt <= '0;
        end else begin
            case (i_cmd.op)
                sws_pkg::OP_MXT: begin
                    r_sx <= r_sx + sws_pkg::SX_W'(r_x) - sws_pkg::SX_W'(r_ox);
                    r_st <= r_st + sws_pkg::ST_W'(r_t) - sws_pkg::ST_W'(r_ot);
                end
                sws_pkg::OP_MOXT: r_sxt <= r_sxt + sws_pkg::SXT_W'(r_prod);
                sws_pkg::OP_MTT:  r_sxt <= r_sxt - sws_pkg::SXT_W'(r_prod);
                sws_pkg::OP_MOTT: r_stt <= r_stt + sws_pkg::STT_W'(r_prod);
                sws_pkg::OP_MSQ:  r_stt <= r_stt - sws_pkg::STT_W'(r_prod);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            sws_pkg::OP_MSXT: begin
                r_den <= sws_pkg::DEN_W'(r_stt) * sws_pkg::DEN_W'(WINDOW)
                         - sws_pkg::DEN_W'(r_prod);
            end
            sws_pkg::OP_NUM: begin
                r_num <= sws_pkg::NUM_W'(r_sxt) * sws_pkg::NUM_W'(WINDOW) - r_prod;
            end
            sws_pkg::OP_CHECK: begin
                r_neg <= r_num[sws_pkg::NUM_W-1];
                r_mag <= r_num[sws_pkg::NUM_W-1] ? sws_pkg::MAG_W'(-r_num)
                                                 : sws_pkg::MAG_W'(r_num);
            end
            default: begin
            end
        endcase
    end

    assign thr   = (i_min_den == '0) ? sws_pkg::THR_W'(1) : i_min_den;
    assign degen = r_den[sws_pkg::DEN_W-1] || (r_den == '0)
                   || (r_den[sws_pkg::DEN_W-2:0] < sws_pkg::DIVD_W'(thr));

    sws_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_mag   (r_mag),
        .i_den   (r_den[sws_pkg::DIVD_W-1:0]),
        .o_busy  (div_busy),
        .o_q     (q)
    );

    always_comb begin
        if (r_neg) begin
            q_sat   = (q > sws_pkg::NEG_MAX) ? sws_pkg::NEG_MAX : q;
            o_slope = sws_pkg::SLOPE_W'(-q_sat);
        end else begin
            q_sat   = (q > sws_pkg::POS_MAX) ? sws_pkg::POS_MAX : q;
            o_slope = sws_pkg::SLOPE_W'(q_sat);
        end
        if (degen) begin
            o_slope = '0;
        end
    end

    assign o_degen         = degen;
    assign o_stat.degen    = degen;
    assign o_stat.div_busy = div_busy;

    `SWS_ASSERT_NXT(a_ring_valid, i_clk, i_rst_n, i_cmd.op == sws_pkg::OP_ACCEPT, r_vld[$past(r_idx)])
    `SWS_ASSERT_NOW(a_idx_range, i_clk, i_rst_n, 1'b1, r_idx <= IDX_W'(WINDOW - 1))

endmodule

FILE: sv/sliding_window_slope_core.sv
// Sliding-window least-squares slope estimator. Each input item is one
// sample (sample_value, sample_time); the core keeps the last WINDOW samples
// (all zero after reset) and running sums, and returns one result item per
// input: the slope (n*Sxt - Sx*St)/(n*Stt - St^2) with n = WINDOW, in
// value units per tick with 16 fractional bits, truncated toward zero and
// saturated to 48 bits. When the denominator is below min_denominator (a
// setting of 0 acts as 1) the slope is 0 and tuser flags it. Items are
// handled one at a time, sequenced by eight steps around one shared
// 31x27 multiplier and, unless the window is degenerate, a 73-step
// restoring divider that retires one quotient bit per cycle; a stalled
// output holds the core until the output register is free. A finished
// result sits in the output register, so the next item is taken while it
// waits. Write min_denominator only while the core is idle.
module sliding_window_slope_core #(
    parameter int WINDOW = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // [23:0] sample_value, [43:24] sample_time

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [47:0] slope
    output logic [0:0]  m_axis_tuser,   // [0] degenerate

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [20:0] i_cfg_data      // min_denominator
);

    logic [sws_pkg::THR_W-1:0]   r_min_den;
    logic                        r_ovalid;
    logic [sws_pkg::SLOPE_W-1:0] r_slope;
    logic                        r_degen;

    sws_pkg::t_cmd               cmd;
    sws_pkg::t_dstat             dstat;
    logic                        out_free;
    logic [sws_pkg::SLOPE_W-1:0] slope;
    logic                        degen;

    assign o_cfg_ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_den <= sws_pkg::THR_W'(1);
        end else if (i_cfg_valid) begin
            r_min_den <= i_cfg_data;
        end
    end

    assign out_free = !r_ovalid || m_axis_tready;

    sws_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (s_axis_tvalid),
        .i_out_free (out_free),
        .i_stat     (dstat),
        .o_s_ready  (s_axis_tready),
        .o_cmd      (cmd)
    );

    sws_dpath #(
        .WINDOW (WINDOW)
    ) u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_x       (s_axis_tdata[sws_pkg::X_W-1:0]),
        .i_t       (s_axis_tdata[sws_pkg::X_W+sws_pkg::T_W-1:sws_pkg::X_W]),
        .i_min_den (r_min_den),
        .o_stat    (dstat),
        .o_slope   (slope),
        .o_degen   (degen)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (cmd.load_out) begin
            r_ovalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.load_out) begin
            r_slope <= slope;
            r_degen <= degen;
        end
    end

    assign m_axis_tvalid   = r_ovalid;
    assign m_axis_tdata    = r_slope;
    assign m_axis_tuser[0] = r_degen;

    `SWS_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, !r_ovalid || m_axis_tready)
    `SWS_ASSERT_NOW(a_degen_zero, i_clk, i_rst_n, r_ovalid && r_degen, r_slope == '0)

endmodule
